>>> design/fskm_pkg.sv
// Shared constants, types and the quarter-wave sine table for the FSK modulator.
// The table is built at elaboration by a constant function; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fskm_pkg;

   localparam int PHASE_BITS = 32;
   localparam int TABLE_BITS = 10;

   localparam int STEP_W   = 32;
   localparam int AMP_W    = 10;
   localparam int SAMPLE_W = 11;
   localparam int SINE_W   = 16;
   localparam int QADDR_W  = TABLE_BITS - 1;
   localparam int QUARTER  = 1 << (TABLE_BITS - 2);
   localparam int SUM_W    = (PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W;

   localparam logic [STEP_W-1:0] MARK_STEP_RESET  = 32'd536870912;
   localparam logic [STEP_W-1:0] SPACE_STEP_RESET = 32'd984263339;
   localparam logic [AMP_W-1:0]  AMPLITUDE_RESET  = 10'd500;

   typedef enum logic [1:0] {
      CSR_MARK_STEP  = 2'd0,
      CSR_SPACE_STEP = 2'd1,
      CSR_AMPLITUDE  = 2'd2
   } csr_index_type;

   typedef logic [SINE_W-1:0] qtab_type [0:QUARTER];

   localparam logic [63:0] PIHALF_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30    = 64'd1073741824;

   // Quarter wave of sine in Q1.15 from a Q30 Taylor series through the x^15 term.
   function automatic qtab_type build_qtab();
      qtab_type          tab;
      logic [63:0]        x;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        usum;
      logic [63:0]        scaled;
      int                 q;
      int                 n;
      for (q = 0; q <= QUARTER; q++) begin
         x    = (PIHALF_Q30 * 64'(q)) / 64'(QUARTER);
         term = x;
         sum  = signed'(x);
         for (n = 1; n <= 7; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > signed'(ONE_Q30)) begin
            sum = signed'(ONE_Q30);
         end
         usum   = unsigned'(sum);
         scaled = (usum * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
         tab[q] = scaled[SINE_W-1:0];
      end
      return tab;
   endfunction

   localparam qtab_type QTAB = build_qtab();

endpackage

`default_nettype wire

>>> design/fsk_sine_modulator_core.sv
// Continuous-phase binary FSK sample generator: phase accumulator, sine lookup
// and amplitude scaling. Depends on fskm_pkg for widths, resets and the sine table.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   req_* carries one data bit per sample tick (one selects the mark increment).
//   rsp_* returns one signed sample in microamps for every accepted bit, in order.
//   csr_* writes mark_step (0), space_step (1) and amplitude (2); other indexes are
//   dropped. csr_ready is always high; write only while no samples are in flight.
// A bit's sample reaches rsp_tvalid through the phase, sine and output registers, in order.
// Throughput: one bit per cycle unless a stall (below) fills the pipe. Only the 32-bit
//   phase add sits in the feedback loop; the table lookup and the 10x16 multiply each
//   have a pipeline stage of their own behind it.
// Stalls: the three stages hold their contents while rsp_tready is low and the
//   pipe is full; req_tready drops only once every stage holds a sample, so a
//   stalled receiver costs no samples and no bits.
// Reset: synchronous, active high. It clears the phase to zero, empties the
//   pipe and restores the register defaults (1200 Hz / 2200 Hz at 9600 Hz,
//   amplitude 500 uA).
module fsk_sine_modulator_core
   import fskm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [0] bit_req, [7:1] zero
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata,   // [10:0] sample, [15:11] zero
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   logic [STEP_W-1:0]            mark_step_ff;
   logic [STEP_W-1:0]            space_step_ff;
   logic [AMP_W-1:0]             amplitude_ff;
   logic [PHASE_BITS-1:0]        phase_ff;
   logic [PHASE_BITS-1:0]        phase_in;
   logic                         ph_valid_ff;
   logic                         sine_valid_ff;
   logic signed [SINE_W-1:0]     sine_ff;
   logic signed [SINE_W-1:0]     sine_in;
   logic                         rsp_valid_ff;
   logic [SAMPLE_W-1:0]          sample_ff;
   logic [SAMPLE_W-1:0]          sample_in;

   logic                         req_xfer;
   logic                         out_adv;
   logic                         sine_adv;
   logic                         ph_adv;
   logic [STEP_W-1:0]            step;
   logic [SUM_W-1:0]             phase_sum;
   logic [TABLE_BITS-1:0]        tab_idx;
   logic [1:0]                   quadrant;
   logic [QADDR_W-1:0]           q_off;
   logic [QADDR_W-1:0]           q_addr;
   logic [SINE_W-1:0]            q_val;
   logic signed [AMP_W+SINE_W:0] prod;
   logic signed [AMP_W+SINE_W:0] rounded;

   // Pipeline advance, from the output back to the input.
   assign out_adv    = !rsp_valid_ff || rsp_tready;
   assign sine_adv   = !sine_valid_ff || out_adv;
   assign ph_adv     = !ph_valid_ff || sine_adv;
   assign req_tready = ph_adv;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      step      = req_tdata[0] ? mark_step_ff : space_step_ff;
      phase_sum = SUM_W'(phase_ff) + SUM_W'(step);
      phase_in  = phase_sum[PHASE_BITS-1:0];
   end

   // Sine lookup with quarter-wave symmetry.
   always_comb begin
      tab_idx  = phase_ff[PHASE_BITS-1 -: TABLE_BITS];
      quadrant = tab_idx[TABLE_BITS-1 -: 2];
      q_off    = {1'b0, tab_idx[TABLE_BITS-3:0]};
      if (quadrant[0]) begin
         q_addr = QADDR_W'(QUARTER) - q_off;
      end else begin
         q_addr = q_off;
      end
      q_val = QTAB[q_addr];
      if (quadrant[1]) begin
         sine_in = -signed'(q_val);
      end else begin
         sine_in = signed'(q_val);
      end
   end

   // Scale and round: floor((amplitude * sine + 2^14) / 2^15).
   always_comb begin
      prod      = signed'({1'b0, amplitude_ff}) * (AMP_W+SINE_W+1)'(sine_ff);
      rounded   = (prod + (AMP_W+SINE_W+1)'(16384)) >>> 15;
      sample_in = rounded[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_step_ff  <= MARK_STEP_RESET;
         space_step_ff <= SPACE_STEP_RESET;
         amplitude_ff  <= AMPLITUDE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MARK_STEP:  mark_step_ff  <= csr_data;
            CSR_SPACE_STEP: space_step_ff <= csr_data;
            CSR_AMPLITUDE:  amplitude_ff  <= csr_data[AMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The phase register doubles as the first pipeline stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         ph_valid_ff   <= 1'b0;
         sine_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_xfer) begin
            phase_ff <= phase_in;
         end
         if (ph_adv) begin
            ph_valid_ff <= req_xfer;
         end
         if (sine_adv) begin
            sine_valid_ff <= ph_valid_ff;
         end
         if (out_adv) begin
            rsp_valid_ff <= sine_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sine_adv && ph_valid_ff) begin
         sine_ff <= sine_in;
      end
      if (out_adv && sine_valid_ff) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, sample_ff};

   // The accumulator moves only on an input transfer.
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !req_xfer |=> $stable(phase_ff))
      else $error("phase changed without an input transfer");

   a_phase_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (phase_ff == '0 && !ph_valid_ff && !sine_valid_ff && !rsp_valid_ff))
      else $error("pipeline not cleared by reset");

   // A full pipe with a stalled receiver must refuse input.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (ph_valid_ff && sine_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while the pipe is full and stalled");

   // A stalled sample in the middle stage is not dropped.
   a_sine_keep: assert property (@(posedge clock) disable iff (reset)
      (sine_valid_ff && !out_adv) |=> (sine_valid_ff && $stable(sine_ff)))
      else $error("middle stage lost its sample under stall");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !ph_valid_ff |-> req_tready)
      else $error("input refused with an empty first stage");

endmodule

`default_nettype wire
